FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DEF_CAPACITY      = 16;
  localparam int unsigned DEF_PAYLOAD_WIDTH = 32;
  localparam int unsigned KEY_W             = 32;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned COUNT_W           = 5;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned CMD_W             = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the new entry (queue not full)
    logic rem;   // drop the front entry, everything moves one cell forward
    logic clr;   // invalidate all cells
    logic desc;  // largest key at front
  } ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// One storage cell of the sorted queue chain: key, payload and valid bit.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PayloadWidth = DEF_PAYLOAD_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  input  logic signed [KEY_W-1:0] new_key_i,
  input  logic [PayloadWidth-1:0] new_payload_i,
  // neighbor toward the front
  input  logic                    prev_valid_i,
  input  logic signed [KEY_W-1:0] prev_key_i,
  input  logic [PayloadWidth-1:0] prev_payload_i,
  // neighbor toward the back
  input  logic                    next_valid_i,
  input  logic signed [KEY_W-1:0] next_key_i,
  input  logic [PayloadWidth-1:0] next_payload_i,
  // insert point already found in an earlier cell
  input  logic                    taken_i,
  output logic                    taken_o,
  output logic                    valid_o,
  output logic signed [KEY_W-1:0] key_o,
  output logic [PayloadWidth-1:0] payload_o
);

  logic                    valid_q, valid_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [PayloadWidth-1:0] payload_q, payload_d;
  logic                    beats;
  logic                    take;

  // new key strictly beats the held key under the current order
  assign beats = ctrl_i.desc ? (new_key_i > key_q) : (new_key_i < key_q);
  // first empty cell, or first held entry that loses, is the insert point
  assign take    = !valid_q || beats;
  assign taken_o = taken_i || take;

  // next contents
  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    payload_d = payload_q;
    priority if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.ins) begin
      if (taken_i) begin
        valid_d   = prev_valid_i;
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end else if (take) begin
        valid_d   = 1'b1;
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end else if (ctrl_i.rem) begin
      valid_d   = next_valid_i;
      key_d     = next_key_i;
      payload_d = next_payload_i;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry data, no reset
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign valid_o   = valid_q;
  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: command decode, cell chain, result register.
`timescale 1ns / 1ps
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: cmd; tdata: new_key, new_payload
//  m_axis   | out       | tdata: front_payload, entry_count; tuser: status
//  cfg      | in        | order_descending, written when cfg_valid_i is high
//
//  One command per cycle: the whole cell chain updates at the accepting edge
//  and the result beat is registered for the next cycle. The insert point is
//  found by one key compare per cell and a carry of "already taken" along
//  the chain. A held result blocks new commands only while m_axis_tready is
//  low. Reset clears the valid bits and the count; no clearing pass.
//
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY      = DEF_CAPACITY,
  parameter int unsigned PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // commands
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [KEY_W+DATA_W-1:0]
                                s_axis_tdata,   // [31:0] new_key, then new_payload
  input  logic [CMD_W-1:0]      s_axis_tuser,   // cmd
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [31:0] front_payload, [36:32] entry_count
  output logic [STATUS_W-1:0]   m_axis_tuser,   // status
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_wdata_i     // order_descending
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                    desc_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    fire;
  cmd_e                    cmd;
  logic                    full, empty;
  ctrl_t                   ctrl;
  logic signed [KEY_W-1:0] new_key;
  logic [DATA_W-1:0]       new_payload_in;
  logic [PAYLOAD_WIDTH+DATA_W-1:0] pay_in_ext;
  logic [PAYLOAD_WIDTH-1:0] new_payload;
  logic [PAYLOAD_WIDTH+DATA_W-1:0] pay_out_ext;
  logic [CntW+COUNT_W-1:0] cnt_ext;

  logic                    out_valid_q;
  logic [DATA_W-1:0]       out_payload_q, out_payload_d;
  logic [COUNT_W-1:0]      out_count_q;
  status_e                 out_status_q, out_status_d;

  // chain wiring
  logic                     cell_valid   [CAPACITY];
  logic signed [KEY_W-1:0]  cell_key     [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];
  logic [CAPACITY:0]        taken;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  // field unpacking, payload fitted to the stored width
  assign cmd            = cmd_e'(s_axis_tuser);
  assign new_key        = s_axis_tdata[KEY_W-1:0];
  assign new_payload_in = s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
  assign pay_in_ext     = {{PAYLOAD_WIDTH{1'b0}}, new_payload_in};
  assign new_payload    = pay_in_ext[PAYLOAD_WIDTH-1:0];

  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];

  // command decode
  always_comb begin
    ctrl.ins  = fire && (cmd == CMD_INSERT) && !full;
    ctrl.rem  = fire && (cmd == CMD_REMOVE) && !empty;
    ctrl.clr  = fire && (cmd == CMD_CLEAR);
    ctrl.desc = desc_q;
  end

  // cell chain
  assign taken[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     pv, nv;
    logic signed [KEY_W-1:0]  pk, nk;
    logic [PAYLOAD_WIDTH-1:0] pp, np;

    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pk = new_key;
      assign pp = new_payload;
    end else begin : g_mid
      assign pv = cell_valid[i-1];
      assign pk = cell_key[i-1];
      assign pp = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nv = 1'b0;
      assign nk = new_key;
      assign np = new_payload;
    end else begin : g_body
      assign nv = cell_valid[i+1];
      assign nk = cell_key[i+1];
      assign np = cell_payload[i+1];
    end

    spq_cell #(
      .PayloadWidth(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_key_i      (new_key),
      .new_payload_i  (new_payload),
      .prev_valid_i   (pv),
      .prev_key_i     (pk),
      .prev_payload_i (pp),
      .next_valid_i   (nv),
      .next_key_i     (nk),
      .next_payload_i (np),
      .taken_i        (taken[i]),
      .taken_o        (taken[i+1]),
      .valid_o        (cell_valid[i]),
      .key_o          (cell_key[i]),
      .payload_o      (cell_payload[i])
    );
  end

  assign pay_out_ext = {{DATA_W{1'b0}}, cell_payload[0]};

  // count and result
  always_comb begin
    cnt_d         = cnt_q;
    out_payload_d = '0;
    out_status_d  = STATUS_OK;
    unique case (cmd)
      CMD_INSERT: begin
        if (full) begin
          out_status_d = STATUS_FULL;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (empty) begin
          out_status_d = STATUS_EMPTY;
        end else begin
          out_payload_d = pay_out_ext[DATA_W-1:0];
          if (cmd == CMD_REMOVE) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        desc_q <= cfg_wdata_i;
      end
      if (fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_payload_q <= out_payload_d;
      out_count_q   <= cnt_ext[COUNT_W-1:0];
      out_status_q  <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_payload_q};
  assign m_axis_tuser  = out_status_q;

endmodule

FILE: tb/sv/spq_checker.sv
// Checker for the sorted priority queue: watches all channels, predicts results, compares.
`timescale 1ns / 1ps
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [63:0]         s_data_i,    // [31:0] new_key, [63:32] new_payload
  input  logic [CMD_W-1:0]    s_user_i,    // cmd
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [39:0]         m_data_i,    // [31:0] front_payload, [36:32] entry_count
  input  logic [STATUS_W-1:0] m_user_i,    // status
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_wdata_i, // order_descending
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0]  payload;
    logic [COUNT_W-1:0] count;
    status_e            status;
  } queue_result_t;

  // Model of the queue contents, front at index 0
  logic signed [KEY_W-1:0] key_q [CAPACITY];
  logic [DATA_W-1:0]       pay_q [CAPACITY];
  int unsigned             fill;
  logic                    desc;

  queue_result_t awaited_q [$];
  int                      err_cnt;

  // True when key a belongs nearer the front than key b
  function automatic bit outranks(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
    return desc ? (a > b) : (a < b);
  endfunction

  // Apply one command to the model and return the result it should produce
  function automatic queue_result_t apply_command(cmd_e c, logic signed [KEY_W-1:0] k,
                                                  logic [DATA_W-1:0] p);
    queue_result_t r;
    int unsigned   pos;
    bit            found;
    r.payload = '0;
    r.status  = STATUS_OK;
    case (c)
      CMD_INSERT: begin
        if (fill >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          // new entry goes before the first entry it strictly beats
          pos   = fill;
          found = 1'b0;
          for (int unsigned i = 0; i < fill; i++) begin
            if (!found && outranks(k, key_q[i])) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int unsigned i = fill; i > pos; i--) begin
            key_q[i] = key_q[i-1];
            pay_q[i] = pay_q[i-1];
          end
          key_q[pos] = k;
          pay_q[pos] = p;
          fill++;
        end
      end
      CMD_REMOVE, CMD_PEEK: begin
        if (fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.payload = pay_q[0];
          if (c == CMD_REMOVE) begin
            for (int unsigned i = 0; i + 1 < fill; i++) begin
              key_q[i] = key_q[i+1];
              pay_q[i] = pay_q[i+1];
            end
            fill--;
          end
        end
      end
      default: begin
        fill = 0;
      end
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  // Per-edge monitor: compare result beats, then predict accepted commands
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      fill      = 0;
      desc      = 1'b0;
      err_cnt   = 0;
      awaited_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with no command outstanding");
          err_cnt++;
        end else begin
          want = awaited_q.pop_front();
          if (m_data_i[31:0] !== want.payload) begin
            $error("front_payload: expected %h, got %h", want.payload, m_data_i[31:0]);
            err_cnt++;
          end
          if (m_data_i[36:32] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_data_i[36:32]);
            err_cnt++;
          end
          if (m_user_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_user_i);
            err_cnt++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        awaited_q.push_back(apply_command(cmd_e'(s_user_i), s_data_i[31:0], s_data_i[63:32]));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        desc = cfg_wdata_i;
      end
      pending_o <= awaited_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

FILE: tb/sv/tb_sorted_priority_queue_unit.sv
// Testbench top for the sorted priority queue: stimulus, stalls and final verdict.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_unit;
  import spq_pkg::*;

  localparam int unsigned N_RANDOM = 1100;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;   // [31:0] new_key, [63:32] new_payload
  logic [CMD_W-1:0]    s_axis_tuser;   // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // [31:0] front_payload, [36:32] entry_count
  logic [STATUS_W-1:0] m_axis_tuser;   // status
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_wdata_i;    // order_descending

  int                  pending;
  int                  fail_cnt;
  int unsigned         n_sent;
  bit                  no_gaps;
  phase_e              phase;
  int unsigned         phase_len;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sorted_priority_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  spq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (fail_cnt)
  );

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Narrow keys make ties common; wide keys exercise every bit
  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'($urandom_range(0, 7)) - 32'd4;
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic cmd_e pick_cmd(phase_e ph);
    int unsigned r;
    int unsigned w_ins;
    int unsigned w_peek;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin w_ins = 75; w_peek = 10; end
      PH_DRAIN: begin w_ins = 20; w_peek = 15; end
      default:  begin w_ins = 45; w_peek = 15; end
    endcase
    if (r < w_ins) return CMD_INSERT;
    if (r < w_ins + w_peek) return CMD_PEEK;
    if (r < 97) return CMD_REMOVE;
    return CMD_CLEAR;
  endfunction

  // Send one command beat, holding it until the queue takes it
  task automatic issue_cmd(input cmd_e c, input logic [31:0] k, input logic [31:0] p);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {p, k};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Change the sort order; only called once the queue is idle
  task automatic write_order(input logic d);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver side: random stalls, with runs of steady readiness
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_INSERT;
    cfg_valid_i   <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    n_sent        = 0;
    no_gaps       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ascending order: empty cases, key extremes, ties
    write_order(1'b0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);
    issue_cmd(CMD_PEEK,   32'h0, 32'h0);
    issue_cmd(CMD_CLEAR,  32'h0, 32'h0);
    issue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_cmd(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
    issue_cmd(CMD_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    issue_cmd(CMD_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
    issue_cmd(CMD_PEEK,   32'h0, 32'h0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);

    // Descending order with one old entry still held, then clear a queue of four entries
    write_order(1'b1);
    issue_cmd(CMD_INSERT, 32'h0000_0005, 32'h0000_0001);
    issue_cmd(CMD_INSERT, 32'h8000_0000, 32'h0000_0002);
    issue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0003);
    issue_cmd(CMD_INSERT, 32'h0000_0005, 32'h0000_0004);
    issue_cmd(CMD_PEEK,   32'h0, 32'h0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);
    issue_cmd(CMD_CLEAR,  32'h0, 32'h0);
    issue_cmd(CMD_PEEK,   32'h0, 32'h0);
    issue_cmd(CMD_REMOVE, 32'h0, 32'h0);

    // Random phases; the order is rewritten at random between phases while entries stay held
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      phase     = phase_e'($urandom_range(0, 2));
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 120);
      repeat (phase_len) begin
        issue_cmd(pick_cmd(phase), pick_key(), $urandom);
      end
      write_order(1'($urandom_range(0, 1)));
    end

    // Let the last results arrive, then a few spare cycles
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
tb/sv/spq_checker.sv
tb/sv/tb_sorted_priority_queue_unit.sv
